// ===== hdl/debounced_press_counter_multitap_clear_core_defines.svh =====
// ---------------------------------------------------------------------------
// debounced press counter assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef DEBOUNCED_PRESS_COUNTER_MULTITAP_CLEAR_CORE_DEFINES_SVH
`define DEBOUNCED_PRESS_COUNTER_MULTITAP_CLEAR_CORE_DEFINES_SVH

`ifndef SYNTH
`define DPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DPC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DPC_ASSERT_IMP(name, ante, cons, msg)
`define DPC_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ===== hdl/dpc_pkg.sv =====
// ---------------------------------------------------------------------------
// dpc_pkg
// shared widths, reset values and codes of the debounced press counter
// ---------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned MS_CFG_W   = 16;
  localparam int unsigned TAPS_W     = 4;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MS_CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_CFG_W-1:0] MAX_GAP_RST    = 16'd1000;
  localparam logic [MS_CFG_W-1:0] WINDOW_RST     = 16'd3000;
  localparam logic [TAPS_W-1:0]   CLEAR_CNT_RST  = 4'd5;
  localparam logic [TAPS_W-1:0]   RUN_FIRST_TAPS = 4'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CNT = 3'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE       = 3'd0,
    EV_RUN_START  = 3'd1,
    EV_CLEARED    = 3'd2,
    EV_TOO_SLOW   = 3'd3,
    EV_GAP_CANCEL = 3'd4,
    EV_TIMEOUT    = 3'd5
  } run_event_e;

endpackage

`default_nettype wire

// ===== hdl/debounced_press_counter_multitap_clear_core.sv =====
// ---------------------------------------------------------------------------
// debounced press counter with multi-tap clear
// debounces an active-low button sample stream, counts presses and clears
// the counter after a run of fast presses within a total window
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o    pin_level_i, now_ms_i
//  out      output     out_valid_o/out_ready_i  press_detected_o .. run_event_o
//  cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  one sample per cycle while the output is not stalled; a sample passes through
//  the input register and then the result register, where its result is presented
//  reset clears all debounce and run state and loads the default registers
//  a stalled result holds; one more sample waits in the input register
// ---------------------------------------------------------------------------
`default_nettype none

`include "debounced_press_counter_multitap_clear_core_defines.svh"

module debounced_press_counter_multitap_clear_core #(
  parameter int unsigned COUNT_WIDTH = dpc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = dpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pin_level_i,
  input  logic [dpc_pkg::NOW_W-1:0]      now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           press_detected_o,
  output logic                           button_held_o,
  output logic [dpc_pkg::TOTAL_W-1:0]    press_total_o,
  output logic [dpc_pkg::TAPS_W-1:0]     fast_taps_o,
  output logic                           run_active_o,
  output logic [dpc_pkg::EVENT_W-1:0]    run_event_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpc_pkg::*;

  // configuration
  logic [MS_CFG_W-1:0] debounce_q, max_gap_q, window_q;
  logic [TAPS_W-1:0]   clear_cnt_q;

  // input register
  logic                  in_valid_q;
  logic                  in_level_q;
  logic [TIME_WIDTH-1:0] in_now_q;
  logic                  advance;

  // block state
  logic                   stable_q, stable_d;
  logic                   raw_prev_q;
  logic [TIME_WIDTH-1:0]  change_time_q, change_time_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   held_q, held_d;
  logic                   run_on_q, run_on_d;
  logic [TAPS_W-1:0]      taps_q, taps_d;
  logic [TIME_WIDTH-1:0]  run_start_q, run_start_d;
  logic [TIME_WIDTH-1:0]  last_tap_q, last_tap_d;

  // result register
  logic                 out_valid_q;
  logic                 press_q;
  logic                 held_out_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [TAPS_W-1:0]    taps_out_q;
  logic                 run_out_q;
  logic [EVENT_W-1:0]   event_q;

  // datapath
  logic [TIME_WIDTH+NOW_W-1:0]    now_ext;
  logic [TIME_WIDTH+MS_CFG_W-1:0] debounce_ext, max_gap_ext, window_ext;
  logic [TIME_WIDTH-1:0]          debounce_t, max_gap_t, window_t;
  logic [TIME_WIDTH-1:0]          el_change, el_last, el_start, el_run;
  logic [COUNT_WIDTH+TOTAL_W-1:0] count_ext;
  logic                           settle, press, gap_ok;
  logic [TAPS_W-1:0]              taps_inc;
  run_event_e                     event_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      max_gap_q   <= MAX_GAP_RST;
      window_q    <= WINDOW_RST;
      clear_cnt_q <= CLEAR_CNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        CFG_MAX_GAP:   max_gap_q   <= cfg_data_i;
        CFG_WINDOW:    window_q    <= cfg_data_i;
        CFG_CLEAR_CNT: clear_cnt_q <= cfg_data_i[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign now_ext    = {{TIME_WIDTH{1'b0}}, now_ms_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_level_q <= pin_level_i;
      in_now_q   <= now_ext[TIME_WIDTH-1:0];
    end
  end

  assign debounce_ext = {{TIME_WIDTH{1'b0}}, debounce_q};
  assign max_gap_ext  = {{TIME_WIDTH{1'b0}}, max_gap_q};
  assign window_ext   = {{TIME_WIDTH{1'b0}}, window_q};
  assign debounce_t   = debounce_ext[TIME_WIDTH-1:0];
  assign max_gap_t    = max_gap_ext[TIME_WIDTH-1:0];
  assign window_t     = window_ext[TIME_WIDTH-1:0];

  // debounce
  assign change_time_d = (in_level_q != raw_prev_q) ? in_now_q : change_time_q;
  assign el_change     = in_now_q - change_time_d;
  assign settle        = (el_change > debounce_t) && (stable_q != in_level_q);
  assign press         = settle && !in_level_q;
  assign stable_d      = settle ? in_level_q : stable_q;
  assign held_d        = settle ? !in_level_q : held_q;

  // fast run
  assign el_last  = in_now_q - last_tap_q;
  assign el_start = in_now_q - run_start_q;
  assign gap_ok   = el_last <= max_gap_t;
  assign taps_inc = taps_q + 1'b1;

  always_comb begin
    logic run_mid;
    logic start_now;
    run_mid     = run_on_q;
    start_now   = 1'b0;
    count_d     = press ? count_q + 1'b1 : count_q;
    taps_d      = taps_q;
    run_start_d = run_start_q;
    last_tap_d  = press ? in_now_q : last_tap_q;
    event_d     = EV_NONE;
    if (press) begin
      if (!run_on_q) begin
        if ((last_tap_q != '0) && gap_ok) begin
          run_mid     = 1'b1;
          start_now   = 1'b1;
          run_start_d = last_tap_q;
          taps_d      = RUN_FIRST_TAPS;
          event_d     = EV_RUN_START;
        end
      end else if (gap_ok) begin
        taps_d = taps_inc;
        if (taps_inc >= clear_cnt_q) begin
          if (el_start <= window_t) begin
            count_d = '0;
            event_d = EV_CLEARED;
          end else begin
            event_d = EV_TOO_SLOW;
          end
          run_mid     = 1'b0;
          taps_d      = '0;
          run_start_d = '0;
        end
      end else begin
        event_d     = EV_GAP_CANCEL;
        run_mid     = 1'b0;
        taps_d      = '0;
        run_start_d = '0;
      end
    end
    el_run = start_now ? el_last : el_start;
    if (run_mid && (el_run > window_t)) begin
      event_d     = EV_TIMEOUT;
      run_mid     = 1'b0;
      taps_d      = '0;
      run_start_d = '0;
    end
    run_on_d = run_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b0;
      raw_prev_q    <= 1'b0;
      change_time_q <= '0;
      count_q       <= '0;
      held_q        <= 1'b0;
      run_on_q      <= 1'b0;
      taps_q        <= '0;
      run_start_q   <= '0;
      last_tap_q    <= '0;
    end else if (advance) begin
      stable_q      <= stable_d;
      raw_prev_q    <= in_level_q;
      change_time_q <= change_time_d;
      count_q       <= count_d;
      held_q        <= held_d;
      run_on_q      <= run_on_d;
      taps_q        <= taps_d;
      run_start_q   <= run_start_d;
      last_tap_q    <= last_tap_d;
    end
  end

  assign count_ext = {{TOTAL_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      press_q    <= press;
      held_out_q <= held_d;
      total_q    <= count_ext[TOTAL_W-1:0];
      taps_out_q <= taps_d;
      run_out_q  <= run_on_d;
      event_q    <= event_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign press_detected_o = press_q;
  assign button_held_o    = held_out_q;
  assign press_total_o    = total_q;
  assign fast_taps_o      = taps_out_q;
  assign run_active_o     = run_out_q;
  assign run_event_o      = event_q;

  `DPC_ASSERT_IMP(a_clear_ends_run, out_valid_o && (run_event_o == EV_CLEARED), (press_total_o == '0) && !run_active_o && (fast_taps_o == '0), "clear left counter or run state")
  `DPC_ASSERT_IMP(a_press_is_held, out_valid_o && press_detected_o, button_held_o, "press without held level")
  `DPC_ASSERT_IMP(a_taps_track_run, out_valid_o, run_active_o == (fast_taps_o != '0), "tap count disagrees with run flag")
  `DPC_ASSERT_NXT(a_stall_keeps_input, in_valid_q && out_valid_o && !out_ready_i, in_valid_q, "queued sample lost during stall")

endmodule

`default_nettype wire
